### rtl/bccs_pkg.sv
// ----------------------------------------------------------------------------
// bccs_pkg
// shared constants, request descriptor type and crc helper for the
// block crc16 check and strip design
// ----------------------------------------------------------------------------
package bccs_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 13;
   localparam int CRC_W  = 16;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

   localparam logic [LEN_W-1:0] DEF_BLOCK_LEN     = 13'd998;
   localparam int               DEF_MAX_BLOCK_LEN = 4096;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_DATA_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CHECK_ENABLE   = 1'b1;

   // queue between framing and check stages
   localparam int QUEUE_DEPTH = 4;

   // one classified request, framing -> check
   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              last_byte;
      logic              bypass;     // checking off, byte passes as is
      logic              done;       // request closes a block
      logic              shorty;     // closed block held a single byte
      logic              out_valid;  // a held data byte is released
      logic [BYTE_W-1:0] out_byte;
   } bccs_desc_type;

   // msb-first crc-16 update over one byte
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/bccs_frame.sv
// ----------------------------------------------------------------------------
// bccs_frame
// front stage: tracks block position and the two-byte hold line, classifies
// each request as data release, block close or bypass
// ----------------------------------------------------------------------------
module bccs_frame import bccs_pkg::*; #(
   parameter int MAX_BLOCK_LEN = DEF_MAX_BLOCK_LEN
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [LEN_W-1:0]    block_data_len,
   input  logic                check_enable,
   input  logic                push,
   input  logic [BYTE_W-1:0]   in_byte,
   input  logic                last_byte,
   output bccs_desc_type       desc
);

   localparam int POS_W = $clog2(MAX_BLOCK_LEN + 2);
   localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              vld0_ff, vld0_in, vld1_ff, vld1_in;
   logic [BYTE_W-1:0] data0_ff, data0_in, data1_ff, data1_in;

   logic [CMP_W-1:0]  len_wide;
   logic [CMP_W-1:0]  len_eff;
   logic [CMP_W-1:0]  limit;
   logic              close;

   // clamp length to 1..MAX_BLOCK_LEN
   always_comb begin
      len_wide = CMP_W'(block_data_len);
      if (len_wide == '0) begin
         len_eff = CMP_W'(1);
      end else if (len_wide > CMP_W'(MAX_BLOCK_LEN)) begin
         len_eff = CMP_W'(MAX_BLOCK_LEN);
      end else begin
         len_eff = len_wide;
      end
      limit = len_eff + CMP_W'(1);
      close = last_byte || (CMP_W'(pos_ff) >= limit);
   end

   always_comb begin
      pos_in   = pos_ff;
      vld0_in  = vld0_ff;
      vld1_in  = vld1_ff;
      data0_in = data0_ff;
      data1_in = data1_ff;

      desc.in_byte   = in_byte;
      desc.last_byte = last_byte;
      desc.bypass    = 1'b0;
      desc.done      = 1'b0;
      desc.shorty    = 1'b0;
      desc.out_valid = 1'b0;
      desc.out_byte  = '0;

      if (!check_enable) begin
         desc.bypass = 1'b1;
         if (push) begin
            pos_in  = '0;
            vld0_in = 1'b0;
            vld1_in = 1'b0;
         end
      end else begin
         desc.out_valid = vld0_ff;
         desc.out_byte  = vld0_ff ? data0_ff : '0;
         desc.done      = close;
         desc.shorty    = close && (pos_ff == '0);
         if (push) begin
            if (close) begin
               pos_in  = '0;
               vld0_in = 1'b0;
               vld1_in = 1'b0;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               vld0_in  = vld1_ff;
               data0_in = data1_ff;
               vld1_in  = 1'b1;
               data1_in = in_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         vld0_ff <= vld0_in;
         vld1_ff <= vld1_in;
      end
   end

   always_ff @(posedge clock) begin
      data0_ff <= data0_in;
      data1_ff <= data1_in;
   end

endmodule

### rtl/bccs_queue.sv
// ----------------------------------------------------------------------------
// bccs_queue
// small fifo of classified requests between the framing and check stages
// ----------------------------------------------------------------------------
module bccs_queue import bccs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  bccs_desc_type push_desc,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output bccs_desc_type head_desc
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bccs_desc_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

### rtl/bccs_check.sv
// ----------------------------------------------------------------------------
// bccs_check
// back stage: runs the crc over each queued request, judges closed blocks,
// keeps the sticky failure flag and holds the response register
// ----------------------------------------------------------------------------
module bccs_check import bccs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  bccs_desc_type     head_desc,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_out_byte_valid,
   output logic              rsp_block_done,
   output logic              rsp_block_crc_ok,
   output logic              rsp_stream_done,
   output logic              rsp_short_tail_error,
   output logic              rsp_any_failure
);

   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              fail_ff, fail_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   logic              ovld_ff, ovld_in;
   logic              done_ff, done_in;
   logic              ok_ff, ok_in;
   logic              sdone_ff, sdone_in;
   logic              short_ff, short_in;
   logic              anyf_ff, anyf_in;

   logic [CRC_W-1:0]  crc_next;
   logic              ok;
   logic              fail_next;
   logic              emit;
   logic              out_free;

   assign crc_next = crc_byte(crc_ff, head_desc.in_byte);
   assign ok       = head_desc.done && !head_desc.shorty && (crc_next == '0);
   assign emit     = head_desc.bypass || head_desc.out_valid || head_desc.done;
   assign out_free = !valid_ff || !rsp_stall;
   // requests without a response only touch state, so they drain past a stall
   assign pop      = head_valid && (!emit || out_free);

   always_comb begin
      crc_in    = crc_ff;
      fail_in   = fail_ff;
      valid_in  = valid_ff && rsp_stall;
      obyte_in  = obyte_ff;
      ovld_in   = ovld_ff;
      done_in   = done_ff;
      ok_in     = ok_ff;
      sdone_in  = sdone_ff;
      short_in  = short_ff;
      anyf_in   = anyf_ff;
      fail_next = fail_ff;

      if (pop) begin
         if (head_desc.bypass) begin
            crc_in = CRC_INIT;
         end else begin
            fail_next = fail_ff || (head_desc.done && !ok);
            crc_in    = head_desc.done ? CRC_INIT : crc_next;
         end
         fail_in = head_desc.last_byte ? 1'b0 : fail_next;

         if (emit) begin
            valid_in = 1'b1;
            obyte_in = head_desc.bypass ? head_desc.in_byte : head_desc.out_byte;
            ovld_in  = head_desc.bypass || head_desc.out_valid;
            done_in  = !head_desc.bypass && head_desc.done;
            ok_in    = !head_desc.bypass && ok;
            sdone_in = head_desc.last_byte;
            short_in = !head_desc.bypass && head_desc.shorty;
            anyf_in  = fail_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         fail_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         fail_ff  <= fail_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      obyte_ff <= obyte_in;
      ovld_ff  <= ovld_in;
      done_ff  <= done_in;
      ok_ff    <= ok_in;
      sdone_ff <= sdone_in;
      short_ff <= short_in;
      anyf_ff  <= anyf_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_out_byte         = obyte_ff;
   assign rsp_out_byte_valid   = ovld_ff;
   assign rsp_block_done       = done_ff;
   assign rsp_block_crc_ok     = ok_ff;
   assign rsp_stream_done      = sdone_ff;
   assign rsp_short_tail_error = short_ff;
   assign rsp_any_failure      = anyf_ff;

endmodule

### rtl/block_crc16_check_strip_top.sv
// ----------------------------------------------------------------------------
// block_crc16_check_strip_top
// checks crc-16 trailers on fixed-size blocks of a byte stream and strips them
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  in_byte, last_byte
//   rsp      out        rsp_valid / rsp_stall  out_byte, flags, any_failure
//   csr      in         csr_write              csr_index, csr_wdata
//
// one request per cycle sustained while rsp_stall is low; the crc update
// is a single byte step in the check stage, so nothing iterates
// an accepted request passes through the queue, then the response
// register; requests that release no byte and close no block give no
// response
// reset is synchronous and active high; csr registers return to length 998
// with checking on
// req_stall rises only when the four-entry queue is full, which happens
// when rsp_stall holds the response register
//
module block_crc16_check_strip_top import bccs_pkg::*; #(
   parameter int MAX_BLOCK_LEN = DEF_MAX_BLOCK_LEN
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_in_byte,
   input  logic                 req_last_byte,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_out_byte_valid,
   output logic                 rsp_block_done,
   output logic                 rsp_block_crc_ok,
   output logic                 rsp_stream_done,
   output logic                 rsp_short_tail_error,
   output logic                 rsp_any_failure,
   // configuration
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_wdata
);

   // configuration registers
   logic [LEN_W-1:0] blen_ff, blen_in;
   logic             chk_en_ff, chk_en_in;

   // front to back
   logic          push;
   logic          full;
   logic          pop;
   logic          head_valid;
   bccs_desc_type push_desc;
   bccs_desc_type head_desc;

   always_comb begin
      blen_in   = blen_ff;
      chk_en_in = chk_en_ff;
      if (csr_write) begin
         case (csr_index)
            REG_BLOCK_DATA_LEN: blen_in   = csr_wdata;
            REG_CHECK_ENABLE:   chk_en_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff   <= DEF_BLOCK_LEN;
         chk_en_ff <= 1'b1;
      end else begin
         blen_ff   <= blen_in;
         chk_en_ff <= chk_en_in;
      end
   end

   // accept whenever the queue has room
   assign req_stall = full;
   assign push      = req_valid && !full;

   // framing: position, hold line, classification
   bccs_frame #(
      .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
   ) u_frame (
      .clock          (clock),
      .reset          (reset),
      .block_data_len (blen_ff),
      .check_enable   (chk_en_ff),
      .push           (push),
      .in_byte        (req_in_byte),
      .last_byte      (req_last_byte),
      .desc           (push_desc)
   );

   // decoupling queue
   bccs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   // crc check, failure tracking, response register
   bccs_check u_check (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_desc            (head_desc),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_out_byte_valid   (rsp_out_byte_valid),
      .rsp_block_done       (rsp_block_done),
      .rsp_block_crc_ok     (rsp_block_crc_ok),
      .rsp_stream_done      (rsp_stream_done),
      .rsp_short_tail_error (rsp_short_tail_error),
      .rsp_any_failure      (rsp_any_failure)
   );

endmodule

### rtl/bccs_checker.sv
// ----------------------------------------------------------------------------
// bccs_checker
// port-level checks on the response channel of the check and strip block
// ----------------------------------------------------------------------------
module bccs_checker import bccs_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_out_byte_valid,
   input logic              rsp_block_done,
   input logic              rsp_block_crc_ok,
   input logic              rsp_stream_done,
   input logic              rsp_short_tail_error,
   input logic              rsp_any_failure
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_block_done) && $stable(rsp_stream_done)
         && $stable(rsp_any_failure))
      else $error("response changed while stalled");

   // a good verdict only comes with a closed block
   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_crc_ok |-> rsp_block_done)
      else $error("crc ok without block done");

   // a short tail is a failed block and shows in the sticky flag
   a_short_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_short_tail_error |->
         rsp_block_done && !rsp_block_crc_ok && rsp_any_failure)
      else $error("short tail not reported as failure");

   // a failed block always raises the sticky flag
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_done && !rsp_block_crc_ok |-> rsp_any_failure)
      else $error("failed block without any_failure");

   // no payload byte means a zero byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_byte_valid |-> rsp_out_byte == '0)
      else $error("out_byte nonzero without payload");

endmodule

bind block_crc16_check_strip_top bccs_checker u_bccs_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_out_byte         (rsp_out_byte),
   .rsp_out_byte_valid   (rsp_out_byte_valid),
   .rsp_block_done       (rsp_block_done),
   .rsp_block_crc_ok     (rsp_block_crc_ok),
   .rsp_stream_done      (rsp_stream_done),
   .rsp_short_tail_error (rsp_short_tail_error),
   .rsp_any_failure      (rsp_any_failure)
);
